@@ sv/lom_pkg.sv @@
// Package for the limit order matcher: sizes, status codes and the structs
// that pass between the book cells and the controller. No dependencies.
package lom_pkg;

  localparam int BOOK_SLOTS = 32;
  localparam int IDX_W      = $clog2(BOOK_SLOTS);
  localparam int CNT_W      = $clog2(BOOK_SLOTS + 1);

  localparam logic [1:0] STAT_TRADE   = 2'd0;
  localparam logic [1:0] STAT_DONE    = 2'd1;
  localparam logic [1:0] STAT_RESTED  = 2'd2;
  localparam logic [1:0] STAT_DROPPED = 2'd3;

  // Running result of one scan along the chain of cells.
  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic [31:0]      match_price;
    logic [31:0]      match_age;
    logic [31:0]      match_owner;
    logic [31:0]      match_rem;
    logic             bid_found;
    logic [31:0]      bid_price;
    logic             ask_found;
    logic [31:0]      ask_price;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } search_t;

  // Write command broadcast to the cells.
  typedef struct packed {
    logic             en;
    logic             rest;
    logic [IDX_W-1:0] idx;
    logic             is_sell;
    logic [31:0]      owner;
    logic [31:0]      price;
    logic [31:0]      remaining;
    logic [31:0]      arrival;
  } wr_t;

endpackage

@@ sv/lom_if.sv @@
// Handshake interfaces for the order and result channels.
// Depends on nothing.
interface lom_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] order_id;
  logic        is_sell;
  logic        is_market;
  logic [31:0] limit_price;
  logic [31:0] order_quantity;

  modport source (output valid, order_id, is_sell, is_market, limit_price, order_quantity,
                  input ready);
  modport sink   (input valid, order_id, is_sell, is_market, limit_price, order_quantity,
                  output ready);
endinterface

interface lom_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] trade_number;
  logic [31:0] buyer_id;
  logic [31:0] seller_id;
  logic [31:0] trade_price;
  logic [31:0] trade_quantity;
  logic [31:0] best_bid;
  logic        bid_present;
  logic [31:0] best_ask;
  logic        ask_present;
  logic        last;

  modport source (output valid, status, trade_number, buyer_id, seller_id, trade_price,
                  trade_quantity, best_bid, bid_present, best_ask, ask_present, last,
                  input ready);
  modport sink   (input valid, status, trade_number, buyer_id, seller_id, trade_price,
                  trade_quantity, best_bid, bid_present, best_ask, ask_present, last,
                  output ready);
endinterface

@@ sv/lom_cell.sv @@
// One book slot: holds a resting order and folds it into the scan word
// that passes from its left neighbor to its right. Depends on lom_pkg.
module lom_cell
  import lom_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             match_side,
  input  logic [31:0]      arr_now,
  input  wr_t              wr,
  input  search_t          srch_in,
  output search_t          srch_out
);

  logic        used_r;
  logic        is_sell_r;
  logic [31:0] owner_r;
  logic [31:0] price_r;
  logic [31:0] rem_r;
  logic [31:0] arrival_r;
  search_t     srch_r;
  search_t     srch_nxt;
  logic [31:0] age;
  logic        cand;
  logic        better;
  logic        hit;

  assign hit = wr.en && (wr.idx == cell_idx);

  // Slot storage: a rest writes the whole order, a fill updates the quantity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (hit) begin
      used_r <= wr.rest || (wr.remaining != 32'd0);
    end
    if (hit) begin
      rem_r <= wr.remaining;
      if (wr.rest) begin
        is_sell_r <= wr.is_sell;
        owner_r   <= wr.owner;
        price_r   <= wr.price;
        arrival_r <= wr.arrival;
      end
    end
  end

  // Compare this slot with the best seen so far on the left.
  always_comb begin
    age    = arr_now - arrival_r;
    cand   = used_r && (is_sell_r == match_side);
    better = !srch_in.match_found ||
             (match_side ? (price_r < srch_in.match_price) : (price_r > srch_in.match_price)) ||
             ((price_r == srch_in.match_price) && (age > srch_in.match_age));
    srch_nxt = srch_in;
    if (cand && better) begin
      srch_nxt.match_found = 1'b1;
      srch_nxt.match_idx   = cell_idx;
      srch_nxt.match_price = price_r;
      srch_nxt.match_age   = age;
      srch_nxt.match_owner = owner_r;
      srch_nxt.match_rem   = rem_r;
    end
    if (used_r && !is_sell_r && (!srch_in.bid_found || (price_r > srch_in.bid_price))) begin
      srch_nxt.bid_found = 1'b1;
      srch_nxt.bid_price = price_r;
    end
    if (used_r && is_sell_r && (!srch_in.ask_found || (price_r < srch_in.ask_price))) begin
      srch_nxt.ask_found = 1'b1;
      srch_nxt.ask_price = price_r;
    end
    if (!used_r && !srch_in.free_found) begin
      srch_nxt.free_found = 1'b1;
      srch_nxt.free_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    srch_r <= srch_nxt;
  end

  assign srch_out = srch_r;

endmodule

@@ sv/limit_order_matcher.sv @@
// Each scan of the book runs through the registered chain of cells.
// An order with F fills needs F+2 scans (one per fill, one that ends matching, one to close), plus output stalls.
// One order is worked at a time; the next is taken once the closing word is loaded.
// The scan word moves one cell per cycle along the chain, and the scan is repeated for every fill.
// Reset (synchronous, rst_n low) empties the book and clears the scan, fill, arrival and trade counters.
// Depends on lom_pkg, lom_if and lom_cell.
module limit_order_matcher
  import lom_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  lom_in_if.sink        in_ch,
  lom_out_if.source     out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;

  logic [1:0]       state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;
  logic [31:0]      arr_r;
  logic [31:0]      tc_r;
  logic [31:0]      id_r;
  logic             sell_r;
  logic             market_r;
  logic [31:0]      price_r;
  logic [31:0]      rem_r;
  logic [31:0]      stamp_r;
  logic [1:0]       stat_r;

  logic             out_valid_r;
  logic [1:0]       o_status_r;
  logic [31:0]      o_tn_r, o_buyer_r, o_seller_r, o_price_r, o_qty_r, o_bid_r, o_ask_r;
  logic             o_bidp_r, o_askp_r, o_last_r;

  search_t          chain_in  [BOOK_SLOTS];
  search_t          chain_out [BOOK_SLOTS];
  search_t          res;
  wr_t              wr;
  logic             scan_done;
  logic             out_free;
  logic             crosses;
  logic             do_trade;
  logic             emit_trade;
  logic             emit_close;
  logic [31:0]      fill;

  // Chain of slot cells, scan word enters empty at the left end.
  always_comb begin
    for (int i = 0; i < BOOK_SLOTS; i++) begin
      if (i == 0) begin
        chain_in[i] = '0;
      end else begin
        chain_in[i] = chain_out[i-1];
      end
    end
  end

  for (genvar g = 0; g < BOOK_SLOTS; g++) begin : g_cell
    lom_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(g)),
      .match_side (!sell_r),
      .arr_now    (arr_r),
      .wr         (wr),
      .srch_in    (chain_in[g]),
      .srch_out   (chain_out[g])
    );
  end

  assign res       = chain_out[BOOK_SLOTS-1];
  assign scan_done = (cnt_r == CNT_W'(BOOK_SLOTS));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign crosses   = market_r ||
                     (sell_r ? !(price_r > res.match_price) : !(price_r < res.match_price));
  assign do_trade  = (rem_r != 32'd0) && (n_r < CNT_W'(BOOK_SLOTS)) &&
                     res.match_found && crosses;
  assign fill      = (rem_r < res.match_rem) ? rem_r : res.match_rem;
  assign emit_trade = (state_r == ST_MATCH) && scan_done && out_free && do_trade;
  assign emit_close = (state_r == ST_CLOSE) && scan_done && out_free;

  // Write command to the cells: fill update or resting remainder.
  always_comb begin
    wr = '0;
    if (emit_trade) begin
      wr.en        = 1'b1;
      wr.idx       = res.match_idx;
      wr.remaining = res.match_rem - fill;
    end else if ((state_r == ST_MATCH) && scan_done && !do_trade &&
                 (rem_r != 32'd0) && !market_r && res.free_found) begin
      wr.en        = 1'b1;
      wr.rest      = 1'b1;
      wr.idx       = res.free_idx;
      wr.is_sell   = sell_r;
      wr.owner     = id_r;
      wr.price     = price_r;
      wr.remaining = rem_r;
      wr.arrival   = stamp_r;
    end
  end

  // Order sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      arr_r   <= '0;
      tc_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            state_r <= ST_MATCH;
            cnt_r   <= '0;
            n_r     <= '0;
            arr_r   <= arr_r + 32'd1;
          end
        end
        ST_MATCH: begin
          if (!scan_done) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else if (do_trade) begin
            if (out_free) begin
              cnt_r <= '0;
              n_r   <= n_r + CNT_W'(1);
              tc_r  <= tc_r + 32'd1;
            end
          end else begin
            state_r <= ST_CLOSE;
            cnt_r   <= '0;
          end
        end
        ST_CLOSE: begin
          if (!scan_done) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Order word and the status decided at the end of matching.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_ch.valid) begin
      id_r     <= in_ch.order_id;
      sell_r   <= in_ch.is_sell;
      market_r <= in_ch.is_market;
      price_r  <= in_ch.limit_price;
      rem_r    <= in_ch.order_quantity;
      stamp_r  <= arr_r;
    end else if (emit_trade) begin
      rem_r <= rem_r - fill;
    end
    if ((state_r == ST_MATCH) && scan_done && !do_trade) begin
      if ((rem_r != 32'd0) && !market_r) begin
        stat_r <= res.free_found ? STAT_RESTED : STAT_DROPPED;
      end else begin
        stat_r <= STAT_DONE;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_trade || emit_close) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit_trade) begin
      o_status_r <= STAT_TRADE;
      o_tn_r     <= tc_r;
      o_buyer_r  <= sell_r ? res.match_owner : id_r;
      o_seller_r <= sell_r ? id_r : res.match_owner;
      o_price_r  <= res.match_price;
      o_qty_r    <= fill;
      o_bid_r    <= '0;
      o_bidp_r   <= 1'b0;
      o_ask_r    <= '0;
      o_askp_r   <= 1'b0;
      o_last_r   <= 1'b0;
    end else if (emit_close) begin
      o_status_r <= stat_r;
      o_tn_r     <= '0;
      o_buyer_r  <= '0;
      o_seller_r <= '0;
      o_price_r  <= '0;
      o_qty_r    <= '0;
      o_bid_r    <= res.bid_found ? res.bid_price : 32'd0;
      o_bidp_r   <= res.bid_found;
      o_ask_r    <= res.ask_found ? res.ask_price : 32'd0;
      o_askp_r   <= res.ask_found;
      o_last_r   <= 1'b1;
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.trade_number   = o_tn_r;
  assign out_ch.buyer_id       = o_buyer_r;
  assign out_ch.seller_id      = o_seller_r;
  assign out_ch.trade_price    = o_price_r;
  assign out_ch.trade_quantity = o_qty_r;
  assign out_ch.best_bid       = o_bid_r;
  assign out_ch.bid_present    = o_bidp_r;
  assign out_ch.best_ask       = o_ask_r;
  assign out_ch.ask_present    = o_askp_r;
  assign out_ch.last           = o_last_r;

`ifndef SYNTHESIS
  a_trade_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit_trade |=> (tc_r == $past(tc_r) + 32'd1))
    else $error("trade number did not advance on a trade");
  a_fill_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(BOOK_SLOTS))
    else $error("fill count exceeded the book size");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("order taken while one is in work");
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    emit_trade |-> ((rem_r != 32'd0) && (fill != 32'd0)))
    else $error("trade emitted with nothing to fill");
`endif

endmodule
